@@ hw/rtl/iidl_pkg.sv @@
// ----------------------------------------------------------------------------
// iidl_pkg
// Shared constants and helpers for the indexed insert/delete list core.
// ----------------------------------------------------------------------------
package iidl_pkg;

    // list capacity and derived widths
    localparam int CAPACITY = 256;
    localparam int ADDR_W   = $clog2(CAPACITY);
    localparam int CNT_W    = $clog2(CAPACITY + 1);
    localparam int POS_W    = 9;
    localparam int DATA_W   = 32;
    localparam int OCNT_W   = 9;
    localparam int CMP_W    = (CNT_W > POS_W) ? CNT_W : POS_W;

    // request kinds
    localparam logic [1:0] KIND_READ   = 2'd0;
    localparam logic [1:0] KIND_INSERT = 2'd1;
    localparam logic [1:0] KIND_APPEND = 2'd2;
    localparam logic [1:0] KIND_DELETE = 2'd3;

    // result status codes
    localparam logic [1:0] ST_DONE  = 2'd0;
    localparam logic [1:0] ST_RANGE = 2'd1;
    localparam logic [1:0] ST_FULL  = 2'd2;

    // value returned when no entry is read
    localparam logic [DATA_W-1:0] NO_VALUE = '1;

    // count as reported on the result port (low 9 bits)
    function automatic logic [OCNT_W-1:0] cnt_out(input logic [CNT_W-1:0] c);
        logic [CMP_W-1:0] ext;
        ext = CMP_W'(c);
        return ext[OCNT_W-1:0];
    endfunction

endpackage

@@ hw/rtl/iidl_ram.sv @@
// ----------------------------------------------------------------------------
// iidl_ram
// Generic simple dual-port RAM: one write port, one read port, registered read.
// ----------------------------------------------------------------------------
module iidl_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 256
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

@@ hw/rtl/indexed_insert_delete_list_core.sv @@
// ----------------------------------------------------------------------------
// indexed_insert_delete_list_core
// Ordered list of signed 32-bit entries with read, insert, append and delete.
// ----------------------------------------------------------------------------
// A request is taken when start is high and busy is low; exactly one result
// follows, shown for one cycle with o_done high, and the receiver cannot stall
// it. Entries live in one RAM with one write and one registered read port, so
// every moved entry is first read (S_INS_RD, S_DEL_RD) and then written (S_INS_WR,
// S_DEL_WR). Requests that are refused (out of range or full) answer on the
// next cycle. busy is low in the cycle the result is shown.
module indexed_insert_delete_list_core (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                start,
    output logic                                busy,
    input  logic [1:0]                          i_kind,
    input  logic [iidl_pkg::POS_W-1:0]          i_position,
    input  logic signed [iidl_pkg::DATA_W-1:0]  i_value,
    output logic                                o_done,
    output logic signed [iidl_pkg::DATA_W-1:0]  o_read_value,
    output logic [1:0]                          o_status,
    output logic [iidl_pkg::OCNT_W-1:0]         o_entry_count
);

    typedef enum logic [2:0] {
        S_IDLE,
        S_READ,
        S_INS_RD,
        S_INS_WR,
        S_INS_PUT,
        S_DEL_RD,
        S_DEL_WR,
        S_DEL_END
    } t_state;

    t_state                              r_state;
    logic [iidl_pkg::CNT_W-1:0]          r_count;
    logic [iidl_pkg::CNT_W-1:0]          r_idx;
    logic [iidl_pkg::ADDR_W-1:0]         r_pos;
    logic [1:0]                          r_kind;
    logic [iidl_pkg::DATA_W-1:0]         r_value;
    logic                                r_done;
    logic [iidl_pkg::DATA_W-1:0]         r_read_value;
    logic [1:0]                          r_status;
    logic [iidl_pkg::OCNT_W-1:0]         r_entry_count;

    logic [iidl_pkg::CMP_W-1:0]          w_pos;
    logic [iidl_pkg::CMP_W-1:0]          w_cnt;
    logic [iidl_pkg::CNT_W-1:0]          w_idx_dn;
    logic [iidl_pkg::CNT_W-1:0]          w_idx_up;
    logic [iidl_pkg::CNT_W-1:0]          w_idx_up2;
    logic                                w_full;

    logic                                ram_we;
    logic [iidl_pkg::ADDR_W-1:0]         ram_waddr;
    logic [iidl_pkg::DATA_W-1:0]         ram_wdata;
    logic [iidl_pkg::ADDR_W-1:0]         ram_raddr;
    logic [iidl_pkg::DATA_W-1:0]         ram_rdata;

    // compare-width views and index neighbors
    assign w_pos     = iidl_pkg::CMP_W'(i_position);
    assign w_cnt     = iidl_pkg::CMP_W'(r_count);
    assign w_idx_dn  = r_idx - iidl_pkg::CNT_W'(1);
    assign w_idx_up  = r_idx + iidl_pkg::CNT_W'(1);
    assign w_idx_up2 = r_idx + iidl_pkg::CNT_W'(2);
    assign w_full    = (r_count == iidl_pkg::CNT_W'(iidl_pkg::CAPACITY));

    // RAM port steering per sequencer state
    always_comb begin
        ram_we    = 1'b0;
        ram_waddr = r_idx[iidl_pkg::ADDR_W-1:0];
        ram_wdata = ram_rdata;
        ram_raddr = w_pos[iidl_pkg::ADDR_W-1:0];
        case (r_state)
            S_INS_RD: begin
                ram_raddr = w_idx_dn[iidl_pkg::ADDR_W-1:0];
            end
            S_INS_WR, S_DEL_WR: begin
                ram_we = 1'b1;
            end
            S_INS_PUT: begin
                ram_we    = 1'b1;
                ram_waddr = r_pos;
                ram_wdata = r_value;
            end
            S_DEL_RD: begin
                ram_raddr = w_idx_up[iidl_pkg::ADDR_W-1:0];
            end
            default: begin
            end
        endcase
    end

    iidl_ram #(
        .WIDTH (iidl_pkg::DATA_W),
        .DEPTH (iidl_pkg::CAPACITY)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_raddr (ram_raddr),
        .o_rdata (ram_rdata)
    );

    // sequencer, count and result registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_count <= '0;
            r_done  <= 1'b0;
        end else begin
            r_done <= 1'b0;
            case (r_state)
                S_IDLE: begin
                    if (start) begin
                        r_kind        <= i_kind;
                        r_value       <= i_value;
                        r_read_value  <= iidl_pkg::NO_VALUE;
                        r_status      <= iidl_pkg::ST_DONE;
                        r_entry_count <= iidl_pkg::cnt_out(r_count);
                        case (i_kind)
                            iidl_pkg::KIND_READ: begin
                                if (w_pos < w_cnt) begin
                                    r_state <= S_READ;
                                end else begin
                                    r_status <= iidl_pkg::ST_RANGE;
                                    r_done   <= 1'b1;
                                end
                            end
                            iidl_pkg::KIND_INSERT: begin
                                r_pos <= w_pos[iidl_pkg::ADDR_W-1:0];
                                r_idx <= r_count;
                                if (w_pos > w_cnt) begin
                                    r_status <= iidl_pkg::ST_RANGE;
                                    r_done   <= 1'b1;
                                end else if (w_full) begin
                                    r_status <= iidl_pkg::ST_FULL;
                                    r_done   <= 1'b1;
                                end else if (w_cnt > w_pos) begin
                                    r_state <= S_INS_RD;
                                end else begin
                                    r_state <= S_INS_PUT;
                                end
                            end
                            iidl_pkg::KIND_APPEND: begin
                                r_pos <= w_cnt[iidl_pkg::ADDR_W-1:0];
                                r_idx <= r_count;
                                if (w_full) begin
                                    r_status <= iidl_pkg::ST_FULL;
                                    r_done   <= 1'b1;
                                end else begin
                                    r_state <= S_INS_PUT;
                                end
                            end
                            default: begin
                                // delete
                                r_idx <= w_pos[iidl_pkg::CNT_W-1:0];
                                if (w_pos >= w_cnt) begin
                                    r_status <= iidl_pkg::ST_RANGE;
                                    r_done   <= 1'b1;
                                end else if (w_pos + iidl_pkg::CMP_W'(1) < w_cnt) begin
                                    r_state <= S_DEL_RD;
                                end else begin
                                    r_state <= S_DEL_END;
                                end
                            end
                        endcase
                    end
                end
                S_READ: begin
                    r_read_value <= ram_rdata;
                    r_done       <= 1'b1;
                    r_state      <= S_IDLE;
                end
                S_INS_RD: begin
                    r_state <= S_INS_WR;
                end
                S_INS_WR: begin
                    // entry idx-1 was copied up into idx
                    r_idx <= w_idx_dn;
                    if (w_idx_dn > iidl_pkg::CNT_W'(r_pos)) begin
                        r_state <= S_INS_RD;
                    end else begin
                        r_state <= S_INS_PUT;
                    end
                end
                S_INS_PUT: begin
                    r_count       <= r_count + iidl_pkg::CNT_W'(1);
                    r_entry_count <= iidl_pkg::cnt_out(r_count + iidl_pkg::CNT_W'(1));
                    r_done        <= 1'b1;
                    r_state       <= S_IDLE;
                end
                S_DEL_RD: begin
                    r_state <= S_DEL_WR;
                end
                S_DEL_WR: begin
                    // entry idx+1 was copied down into idx
                    r_idx <= w_idx_up;
                    if (w_idx_up2 < r_count) begin
                        r_state <= S_DEL_RD;
                    end else begin
                        r_state <= S_DEL_END;
                    end
                end
                S_DEL_END: begin
                    r_count       <= r_count - iidl_pkg::CNT_W'(1);
                    r_entry_count <= iidl_pkg::cnt_out(r_count - iidl_pkg::CNT_W'(1));
                    r_done        <= 1'b1;
                    r_state       <= S_IDLE;
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    assign busy          = (r_state != S_IDLE);
    assign o_done        = r_done;
    assign o_read_value  = r_read_value;
    assign o_status      = r_status;
    assign o_entry_count = r_entry_count;

    // count never passes capacity
    a_count_cap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= iidl_pkg::CNT_W'(iidl_pkg::CAPACITY))
        else $error("entry count above capacity");

    // a full-status refusal only happens on a full list
    a_full_status: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_done && o_status == iidl_pkg::ST_FULL) |-> w_full)
        else $error("full status with room left");

    // a completed insert or append grows the list by one
    a_insert_grows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_done && o_status == iidl_pkg::ST_DONE
         && (r_kind == iidl_pkg::KIND_INSERT || r_kind == iidl_pkg::KIND_APPEND))
        |-> r_count == $past(r_count) + iidl_pkg::CNT_W'(1))
        else $error("insert did not grow the list");

endmodule
